// ===== rtl/core/cgu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cgu_pkg
// Shared types and constants of the column gamma unpacker.
// ----------------------------------------------------------------------------
package cgu_pkg;

    localparam int LANE_COUNT_DEF = 16;   // lanes per codeword, 4..16
    localparam int LANE_BITS      = 32;   // bits per lane word
    localparam int HALF_LANES     = 8;    // lanes per result beat
    localparam int WIDTH_BITS     = 6;    // column width field, 0..32

    typedef logic [LANE_BITS-1:0] lane_word_t;

endpackage

// ===== rtl/core/column_gamma_unpacker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// column_gamma_unpacker_top
// Collects 1 + LANE_COUNT words per codeword, then walks the selector one
// bit per cycle, peeling one bit off every lane per cycle into the column.
// ----------------------------------------------------------------------------
// Sequence: 1 + LANE_COUNT word beats per codeword, then per column one scan
//   step per selector bit up to its set bit, then its two result beats.
// The one-bit-per-cycle shifter walks the selector. Input stalls during decode.
// Reset (rst_n low, async): word count, selector, sequencer and output valid
//   clear; lane and column storage keep whatever they held.
module column_gamma_unpacker_top #(
    parameter int LANE_COUNT = cgu_pkg::LANE_COUNT_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // word channel
    input  logic                           word_valid,
    output logic                           word_stall,
    input  logic [cgu_pkg::LANE_BITS-1:0]  stream_word,
    input  logic                           end_of_section,
    // result channel
    output logic                           result_valid,
    input  logic                           result_stall,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_0,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_1,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_2,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_3,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_4,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_5,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_6,
    output logic [cgu_pkg::LANE_BITS-1:0]  lane_7,
    output logic                           upper_half,
    output logic [cgu_pkg::WIDTH_BITS-1:0] column_width,
    output logic                           codeword_done,
    output logic                           bad_selector
);

    localparam int WC_W      = $clog2(LANE_COUNT + 1);
    localparam int IDX_W     = $clog2(LANE_COUNT);
    localparam int BIT_W     = $clog2(cgu_pkg::LANE_BITS);
    localparam int HALF      = cgu_pkg::HALF_LANES;
    localparam int WIDTH_W   = cgu_pkg::WIDTH_BITS;

    localparam logic [2:0] S_COLLECT = 3'd0;
    localparam logic [2:0] S_BAD     = 3'd1;
    localparam logic [2:0] S_SCAN    = 3'd2;
    localparam logic [2:0] S_HALF0   = 3'd3;
    localparam logic [2:0] S_HALF1   = 3'd4;

    // control
    logic [2:0]                 state_reg, state_next;
    logic [WC_W-1:0]            wc_reg, wc_next;
    logic [cgu_pkg::LANE_BITS-1:0] sel_reg, sel_next;
    logic [BIT_W-1:0]           cnt_reg, cnt_next;
    logic                       out_valid_reg, out_valid_next;

    // payload
    cgu_pkg::lane_word_t        lane_reg [LANE_COUNT];
    cgu_pkg::lane_word_t        lane_next [LANE_COUNT];
    cgu_pkg::lane_word_t        col_reg [LANE_COUNT];
    cgu_pkg::lane_word_t        col_next [LANE_COUNT];
    logic [WIDTH_W-1:0]         width_reg, width_next;
    cgu_pkg::lane_word_t        out_lane_reg [HALF];
    cgu_pkg::lane_word_t        out_lane_next [HALF];
    logic                       out_half_reg, out_half_next;
    logic [WIDTH_W-1:0]         out_width_reg, out_width_next;
    logic                       out_done_reg, out_done_next;
    logic                       out_bad_reg, out_bad_next;

    cgu_pkg::lane_word_t        half0_lane [HALF];
    cgu_pkg::lane_word_t        half1_lane [HALF];

    logic                       word_accept;
    logic                       out_free;
    logic [WC_W-1:0]            wc_minus;
    logic [IDX_W-1:0]           wr_idx;

    assign word_stall   = (state_reg != S_COLLECT);
    assign word_accept  = word_valid && !word_stall;
    assign out_free     = !out_valid_reg || !result_stall;
    assign wc_minus     = wc_reg - WC_W'(1);
    assign wr_idx       = wc_minus[IDX_W-1:0];

    // lanes beyond LANE_COUNT read as zero
    for (genvar i = 0; i < HALF; i++)
    begin : g_half
        if (i < LANE_COUNT)
        begin : g_lo
            assign half0_lane[i] = col_reg[i];
        end
        else
        begin : g_lo_zero
            assign half0_lane[i] = '0;
        end
        if (i + HALF < LANE_COUNT)
        begin : g_hi
            assign half1_lane[i] = col_reg[i + HALF];
        end
        else
        begin : g_hi_zero
            assign half1_lane[i] = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        wc_next        = wc_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        width_next     = width_reg;
        out_valid_next = out_valid_reg;
        out_half_next  = out_half_reg;
        out_width_next = out_width_reg;
        out_done_next  = out_done_reg;
        out_bad_next   = out_bad_reg;
        for (int l = 0; l < LANE_COUNT; l++)
        begin
            lane_next[l] = lane_reg[l];
            col_next[l]  = col_reg[l];
        end
        for (int i = 0; i < HALF; i++)
        begin
            out_lane_next[i] = out_lane_reg[i];
        end

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_COLLECT:
            begin
                if (word_accept)
                begin
                    if (wc_reg == '0)
                    begin
                        sel_next = stream_word;
                    end
                    else
                    begin
                        lane_next[wr_idx] = stream_word;
                    end
                    if (wc_reg == WC_W'(LANE_COUNT))
                    begin
                        wc_next  = '0;
                        cnt_next = '0;
                        for (int l = 0; l < LANE_COUNT; l++)
                        begin
                            col_next[l] = '0;
                        end
                        state_next = (sel_reg == '0) ? S_BAD : S_SCAN;
                    end
                    else if (end_of_section)
                    begin
                        // partial codeword dropped
                        wc_next  = '0;
                        sel_next = '0;
                    end
                    else
                    begin
                        wc_next = wc_reg + WC_W'(1);
                    end
                end
            end
            S_BAD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    for (int i = 0; i < HALF; i++)
                    begin
                        out_lane_next[i] = '0;
                    end
                    out_half_next  = 1'b0;
                    out_width_next = '0;
                    out_done_next  = 1'b1;
                    out_bad_next   = 1'b1;
                    state_next     = S_COLLECT;
                end
            end
            S_SCAN:
            begin
                // one selector bit and one bit of every lane per cycle
                for (int l = 0; l < LANE_COUNT; l++)
                begin
                    col_next[l][cnt_reg] = lane_reg[l][0];
                    lane_next[l]         = lane_reg[l] >> 1;
                end
                sel_next = sel_reg >> 1;
                cnt_next = cnt_reg + BIT_W'(1);
                if (sel_reg[0])
                begin
                    width_next = {{(WIDTH_W-BIT_W){1'b0}}, cnt_reg} + WIDTH_W'(1);
                    state_next = S_HALF0;
                end
            end
            S_HALF0:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    for (int i = 0; i < HALF; i++)
                    begin
                        out_lane_next[i] = half0_lane[i];
                    end
                    out_half_next  = 1'b0;
                    out_width_next = width_reg;
                    out_done_next  = 1'b0;
                    out_bad_next   = 1'b0;
                    state_next     = S_HALF1;
                end
            end
            S_HALF1:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    for (int i = 0; i < HALF; i++)
                    begin
                        out_lane_next[i] = half1_lane[i];
                    end
                    out_half_next  = 1'b1;
                    out_width_next = width_reg;
                    out_done_next  = (sel_reg == '0);
                    out_bad_next   = 1'b0;
                    if (sel_reg == '0)
                    begin
                        state_next = S_COLLECT;
                    end
                    else
                    begin
                        cnt_next = '0;
                        for (int l = 0; l < LANE_COUNT; l++)
                        begin
                            col_next[l] = '0;
                        end
                        state_next = S_SCAN;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_COLLECT;
            wc_reg        <= '0;
            sel_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wc_reg        <= wc_next;
            sel_reg       <= sel_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int l = 0; l < LANE_COUNT; l++)
        begin
            lane_reg[l] <= lane_next[l];
            col_reg[l]  <= col_next[l];
        end
        for (int i = 0; i < HALF; i++)
        begin
            out_lane_reg[i] <= out_lane_next[i];
        end
        width_reg     <= width_next;
        out_half_reg  <= out_half_next;
        out_width_reg <= out_width_next;
        out_done_reg  <= out_done_next;
        out_bad_reg   <= out_bad_next;
    end

    assign result_valid  = out_valid_reg;
    assign lane_0        = out_lane_reg[0];
    assign lane_1        = out_lane_reg[1];
    assign lane_2        = out_lane_reg[2];
    assign lane_3        = out_lane_reg[3];
    assign lane_4        = out_lane_reg[4];
    assign lane_5        = out_lane_reg[5];
    assign lane_6        = out_lane_reg[6];
    assign lane_7        = out_lane_reg[7];
    assign upper_half    = out_half_reg;
    assign column_width  = out_width_reg;
    assign codeword_done = out_done_reg;
    assign bad_selector  = out_bad_reg;

    // the scan only runs on a live selector, so it always finds a set bit
    a_scan_live: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (sel_reg != '0))
        else $error("scan running on an empty selector");

    a_wc_range: assert property (@(posedge clk) disable iff (!rst_n)
        wc_reg <= WC_W'(LANE_COUNT))
        else $error("word count past codeword length");

    a_bad_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && bad_selector) |->
            (codeword_done && !upper_half && (column_width == '0)))
        else $error("malformed bad-selector beat");

    a_good_width: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !bad_selector) |->
            ((column_width != '0) && (column_width <= WIDTH_W'(cgu_pkg::LANE_BITS))))
        else $error("column width out of range");

    // a codeword ends on the upper half beat
    a_done_upper: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && codeword_done && !bad_selector) |-> upper_half)
        else $error("codeword ended on a lower half beat");

endmodule

// ===== tb/tb_column_gamma_unpacker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_column_gamma_unpacker_top
// Feeds codewords (selector + lane words) into the column gamma unpacker and
// checks every half-column beat against an in-bench decoder. Random bursts
// on the word side, patterned stalls on the result side, plus one long
// result hold-off and one sender pause that waits for all beats to drain.
// ----------------------------------------------------------------------------
module tb_column_gamma_unpacker_top;

    localparam int LANES        = cgu_pkg::LANE_COUNT_DEF;
    localparam int RANDOM_WORDS = 240;
    localparam int SETTLE_CYCLES = 200;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_AFTER  = 4;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct packed {
        logic [cgu_pkg::HALF_LANES-1:0][cgu_pkg::LANE_BITS-1:0] lanes;
        logic                                                   upper;
        logic [cgu_pkg::WIDTH_BITS-1:0]                         width;
        logic                                                   done;
        logic                                                   bad;
    } column_beat_t;

    typedef struct packed {
        cgu_pkg::lane_word_t word;
        logic                eos;
        logic                drain;   // not a word: hold until all beats are back
    } feed_item_t;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           word_valid = 1'b0;
    logic                           word_stall;
    cgu_pkg::lane_word_t            stream_word = '0;
    logic                           end_of_section = 1'b0;
    logic                           result_valid;
    logic                           result_stall = 1'b0;
    cgu_pkg::lane_word_t            lane_0, lane_1, lane_2, lane_3;
    cgu_pkg::lane_word_t            lane_4, lane_5, lane_6, lane_7;
    logic                           upper_half;
    logic [cgu_pkg::WIDTH_BITS-1:0] column_width;
    logic                           codeword_done;
    logic                           bad_selector;

    column_gamma_unpacker_top uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .word_valid     (word_valid),
        .word_stall     (word_stall),
        .stream_word    (stream_word),
        .end_of_section (end_of_section),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .lane_0         (lane_0),
        .lane_1         (lane_1),
        .lane_2         (lane_2),
        .lane_3         (lane_3),
        .lane_4         (lane_4),
        .lane_5         (lane_5),
        .lane_6         (lane_6),
        .lane_7         (lane_7),
        .upper_half     (upper_half),
        .column_width   (column_width),
        .codeword_done  (codeword_done),
        .bad_selector   (bad_selector)
    );

    always #10 clk = ~clk;

    feed_item_t   pending_words[$];
    column_beat_t expected_beats[$];
    int           word_total = 0;
    int           words_accepted = 0;
    int           mismatches = 0;
    logic         feed_enable = 1'b0;
    logic         word_taken = 1'b0;
    logic         hold_long = 1'b0;

    // decoder state mirrored in the bench
    int                  gather_count = 0;
    cgu_pkg::lane_word_t sel_bits = '0;
    cgu_pkg::lane_word_t lane_store[16];

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic int lowest_one(input cgu_pkg::lane_word_t v);
        int pos;
        pos = 32;
        for (int i = 31; i >= 0; i--)
        begin
            if (v[i])
            begin
                pos = i + 1;
            end
        end
        return pos;
    endfunction

    function automatic cgu_pkg::lane_word_t keep_low(input cgu_pkg::lane_word_t v,
                                                     input int w);
        if (w >= 32)
        begin
            return v;
        end
        return v & ((cgu_pkg::lane_word_t'(1) << w) - 1);
    endfunction

    function automatic cgu_pkg::lane_word_t drop_low(input cgu_pkg::lane_word_t v,
                                                     input int w);
        if (w >= 32)
        begin
            return '0;
        end
        return v >> w;
    endfunction

    // one accepted word through the decoder; pushes the beats it releases
    task automatic absorb_word(input cgu_pkg::lane_word_t w, input logic eos);
        column_beat_t b;
        int           cw;
        int           lane;
        if (gather_count == 0)
        begin
            sel_bits = w;
        end
        else if (gather_count - 1 < 16)
        begin
            lane_store[gather_count - 1] = w;
        end
        if (gather_count >= LANES)
        begin
            if (sel_bits == '0)
            begin
                b      = '0;
                b.done = 1'b1;
                b.bad  = 1'b1;
                expected_beats.push_back(b);
            end
            while (sel_bits != '0)
            begin
                cw       = lowest_one(sel_bits);
                sel_bits = drop_low(sel_bits, cw);
                for (int h = 0; h < 2; h++)
                begin
                    b = '0;
                    for (int i = 0; i < cgu_pkg::HALF_LANES; i++)
                    begin
                        lane = h * cgu_pkg::HALF_LANES + i;
                        b.lanes[i] = (lane < LANES) ? keep_low(lane_store[lane], cw) : '0;
                    end
                    b.upper = (h == 1);
                    b.width = cw[cgu_pkg::WIDTH_BITS-1:0];
                    b.done  = (h == 1) && (sel_bits == '0);
                    expected_beats.push_back(b);
                end
                for (int i = 0; i < 16; i++)
                begin
                    lane_store[i] = drop_low(lane_store[i], cw);
                end
            end
            gather_count = 0;
        end
        else if (eos)
        begin
            gather_count = 0;
            sel_bits     = '0;
        end
        else
        begin
            gather_count++;
        end
    endtask

    task automatic queue_word(input cgu_pkg::lane_word_t w, input logic eos);
        feed_item_t it;
        it.word  = w;
        it.eos   = eos;
        it.drain = 1'b0;
        pending_words.push_back(it);
        word_total++;
    endtask

    task automatic queue_drain();
        feed_item_t it;
        it.word  = '0;
        it.eos   = 1'b0;
        it.drain = 1'b1;
        pending_words.push_back(it);
    endtask

    function automatic cgu_pkg::lane_word_t random_lane();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
        begin
            return '1;
        end
        if (pick == 1)
        begin
            return '0;
        end
        return $urandom;
    endfunction

    // selector as a run of column widths, mostly narrow ones
    function automatic cgu_pkg::lane_word_t composed_selector();
        cgu_pkg::lane_word_t s;
        int                  pos;
        int                  w;
        logic                stop;
        s    = '0;
        pos  = 0;
        stop = 1'b0;
        while (pos < 32 && !stop)
        begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 32) : $urandom_range(1, 5);
            if (pos + w > 32)
            begin
                w = 32 - pos;
            end
            s   = s | (cgu_pkg::lane_word_t'(1) << (pos + w - 1));
            pos = pos + w;
            stop = ($urandom_range(0, 7) == 0);
        end
        return s;
    endfunction

    task automatic queue_codeword(input cgu_pkg::lane_word_t sel, input logic eos_on_last);
        queue_word(sel, 1'b0);
        for (int i = 0; i < LANES; i++)
        begin
            queue_word(random_lane(), (i == LANES - 1) ? eos_on_last : 1'b0);
        end
    endtask

    // result check first, then the word prediction, so the order is fixed
    always @(posedge clk)
    begin
        column_beat_t got;
        column_beat_t want;
        if (result_valid && !result_stall)
        begin
            got.lanes = {lane_7, lane_6, lane_5, lane_4, lane_3, lane_2, lane_1, lane_0};
            got.upper = upper_half;
            got.width = column_width;
            got.done  = codeword_done;
            got.bad   = bad_selector;
            if (expected_beats.size() == 0)
            begin
                report_mismatch($sformatf("unexpected beat width=%0d upper=%0b",
                                          got.width, got.upper));
            end
            else
            begin
                want = expected_beats.pop_front();
                for (int i = 0; i < cgu_pkg::HALF_LANES; i++)
                begin
                    if (got.lanes[i] !== want.lanes[i])
                    begin
                        report_mismatch($sformatf("lane_%0d got %h want %h (upper=%0b)",
                                                  i, got.lanes[i], want.lanes[i], want.upper));
                    end
                end
                if (got.upper !== want.upper)
                begin
                    report_mismatch($sformatf("upper_half got %0b want %0b",
                                              got.upper, want.upper));
                end
                if (got.width !== want.width)
                begin
                    report_mismatch($sformatf("column_width got %0d want %0d",
                                              got.width, want.width));
                end
                if (got.done !== want.done)
                begin
                    report_mismatch($sformatf("codeword_done got %0b want %0b",
                                              got.done, want.done));
                end
                if (got.bad !== want.bad)
                begin
                    report_mismatch($sformatf("bad_selector got %0b want %0b",
                                              got.bad, want.bad));
                end
            end
        end
        word_taken = word_valid && !word_stall;
        if (word_taken)
        begin
            absorb_word(stream_word, end_of_section);
            words_accepted++;
        end
    end

    // word driver: bursts of beats with random gaps
    int burst_left = 0;
    int gap_left = 0;

    always @(negedge clk)
    begin
        feed_item_t it;
        if (feed_enable && !(word_valid && !word_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                word_valid <= 1'b0;
            end
            else if (pending_words.size() == 0)
            begin
                word_valid <= 1'b0;
            end
            else if (pending_words[0].drain)
            begin
                word_valid <= 1'b0;
                if (expected_beats.size() == 0)
                begin
                    void'(pending_words.pop_front());
                end
            end
            else
            begin
                it = pending_words.pop_front();
                word_valid     <= 1'b1;
                stream_word    <= it.word;
                end_of_section <= it.eos;
                if (burst_left > 0)
                begin
                    burst_left--;
                end
                else
                begin
                    burst_left = $urandom_range(0, 20);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
        end
    end

    // result stall pattern, overridden by the long hold-off
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          stall_phase = 0;

    always @(negedge clk)
    begin
        logic hold_now;
        if (stall_left == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(20, 120);
        end
        else
        begin
            stall_left--;
        end
        stall_phase++;
        case (stall_mode)
            STALL_NONE:     hold_now = 1'b0;
            STALL_LIGHT:    hold_now = ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    hold_now = ($urandom_range(0, 3) != 0);
            default:        hold_now = ((stall_phase % 7) < 3);
        endcase
        result_stall <= hold_long || hold_now;
    end

    initial
    begin
        wait (words_accepted >= 100);
        @(posedge clk);
        hold_long = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_long = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int                  kind;
        int                  cut;
        int                  codewords;
        cgu_pkg::lane_word_t sel;

        for (int i = 0; i < 16; i++)
        begin
            lane_store[i] = '0;
        end

        // directed: one full-width column with extreme lane words
        queue_word(32'h8000_0000, 1'b0);
        for (int i = 0; i < LANES; i++)
        begin
            queue_word((i % 3 == 0) ? '1 : ((i % 3 == 1) ? '0 : 32'hA5C3_0F96), 1'b0);
        end
        // partial codeword cut by an end marker, then a lone marked selector
        queue_word(32'hFFFF_FFFF, 1'b0);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b1);
        queue_word(32'h0000_0001, 1'b1);

        // early forced cases: zero selector, then all-ones with marker on last lane
        queue_codeword('0, 1'b0);
        queue_codeword('1, 1'b1);

        codewords = 0;
        while (word_total < 21 + RANDOM_WORDS)
        begin
            kind = $urandom_range(0, 15);
            if (kind == 13 || kind == 14)
            begin
                // broken codeword: end marker before the last lane
                cut = $urandom_range(1, LANES);
                for (int i = 0; i < cut; i++)
                begin
                    queue_word((i == 0) ? composed_selector() : random_lane(),
                               i == cut - 1);
                end
            end
            else if (kind == 15)
            begin
                queue_word($urandom, $urandom_range(0, 3) != 0);
            end
            else
            begin
                case (kind)
                    0:       sel = '0;
                    1:       sel = '1;
                    2:       sel = cgu_pkg::lane_word_t'(1) << $urandom_range(0, 31);
                    3:       sel = $urandom;
                    default: sel = composed_selector();
                endcase
                queue_codeword(sel, $urandom_range(0, 3) == 0);
                codewords++;
                if (codewords == DRAIN_AFTER)
                begin
                    queue_drain();
                end
            end
        end
        if (codewords < DRAIN_AFTER)
        begin
            queue_drain();
        end
        // a last clean codeword so the tail of the run decodes
        queue_codeword(composed_selector(), 1'b1);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        feed_enable = 1'b1;

        wait (words_accepted == word_total);
        wait (expected_beats.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_beats.size() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
